FILE: rtl/core/sha256_pkg.sv
// SHA-256 package: round constants, initial hash values, state type and round functions.
// Used by the byte-stream hasher core and its testbench.
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_byte_if.sv
// Byte input channel interface for the SHA-256 hasher.
// Stand-alone; no package dependency.
`default_nettype none
interface sha256_byte_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha256_digest_if.sv
// Digest output channel interface for the SHA-256 hasher.
// Stand-alone; no package dependency.
`default_nettype none
interface sha256_digest_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level. Depends on sha256_pkg and the channel interfaces.
// A byte beat that fills a block holds input off through the load, round and update
// states. An end beat adds one padding write per position up to byte 63, one or two
// compressions and eight output beats. Throughput is set by the one-byte-per-cycle
// block memory port and the one round per cycle compression. Reset (rst, synchronous)
// restores the initial hash values and zeroes the counts.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire logic clk,
  input  wire logic rst,
  sha256_byte_if.sink     in_ch,
  sha256_digest_if.source out_ch
);
  import sha256_pkg::*;

  // Block buffer memory: 64 bytes, one write port, one registered read port.
  logic [7:0]  block_mem [64];
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic        mem_we;
  logic [5:0]  mem_raddr;
  logic [7:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= block_mem[mem_raddr];
  end

  state_t      state, state_next;
  logic [31:0] hash_words [8];
  logic [31:0] wv [8];
  logic [31:0] sched [16];
  logic [5:0]  fill_count;
  logic [60:0] byte_count;
  logic [6:0]  step;          // load byte counter / round counter
  logic        final_block;   // current compression is the last of the message
  logic        pad_second;    // padding needs an extra block first
  logic        pending_pad;   // end beat waits for a full-block compression
  logic        mark_pending;  // the 0x80 marker byte is still to be written
  logic [2:0]  emit_idx;
  logic [63:0] bit_len;

  assign bit_len = {byte_count, 3'b000};

  logic in_fire;
  logic in_ready_w;
  assign in_ready_w = (state == ST_COLLECT);
  assign in_ch.ready = in_ready_w;
  assign in_fire = in_ch.valid && in_ready_w;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_fire) begin
          if (in_ch.has_byte && fill_count == 6'd63) state_next = ST_LOAD;
          else if (in_ch.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill_count == 6'd63) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (step == 7'd64) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (step == 7'd63) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (pending_pad) state_next = ST_PAD;
        else if (final_block && !pad_second) state_next = ST_EMIT;
        else if (final_block) state_next = ST_PAD;
        else state_next = ST_COLLECT;
      end
      ST_EMIT: begin
        if (out_ch.ready && emit_idx == 3'd7) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Padding byte for the current fill position: marker first, then zeros and the length.
  logic [7:0] pad_byte;
  always_comb begin
    if (mark_pending) begin
      pad_byte = PAD_BYTE;
    end else if (pad_second) begin
      pad_byte = 8'h00;
    end else if (fill_count >= LEN_START) begin
      pad_byte = bit_len[{~fill_count[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_count;
    mem_wdata = in_ch.data_byte;
    mem_raddr = step[5:0];
    unique case (state)
      ST_COLLECT: begin
        if (in_fire && in_ch.has_byte) mem_we = 1'b1;
      end
      ST_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = pad_byte;
      end
      default: ;
    endcase
  end

  // Round datapath.
  logic [31:0] w_cur, w_new, t1, t2;
  assign w_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];
  assign w_cur = (step < 7'd16) ? sched[0] : w_new;
  assign t1 = wv[7] + big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + ROUND_K[step[5:0]] + w_cur;
  assign t2 = big_sigma0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      fill_count   <= '0;
      byte_count   <= '0;
      step         <= '0;
      final_block  <= 1'b0;
      pad_second   <= 1'b0;
      pending_pad  <= 1'b0;
      mark_pending <= 1'b0;
      emit_idx     <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
    end else begin
      state <= state_next;
      unique case (state)
        ST_COLLECT: begin
          step <= '0;
          if (in_fire) begin
            if (in_ch.has_byte) begin
              fill_count <= fill_count + 6'd1;
              byte_count <= byte_count + 61'd1;
            end
            // An end beat leaves the marker to the pad state; a full block compresses first.
            pending_pad  <= in_ch.has_byte && in_ch.end_of_message && fill_count == 6'd63;
            mark_pending <= in_ch.end_of_message;
            final_block  <= 1'b0;
          end
        end
        ST_PAD: begin
          step <= '0;
          fill_count <= fill_count + 6'd1;
          if (mark_pending) begin
            // Marker written this cycle; decide whether the length still fits.
            mark_pending <= 1'b0;
            pad_second   <= (fill_count > 6'd55);
          end
          if (fill_count == 6'd63) final_block <= 1'b1;
        end
        ST_LOAD: begin
          if (step != 7'd0) begin
            sched[15] <= {sched[15][23:0], mem_rdata};
            if (step[1:0] == 2'd1 && step != 7'd1) begin
              for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
            end
          end
          if (step == 7'd64) begin
            for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
            step <= '0;
          end else begin
            step <= step + 7'd1;
          end
        end
        ST_ROUND: begin
          step <= step + 7'd1;
          for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
          sched[15] <= w_cur;
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
        end
        ST_UPDATE: begin
          step <= '0;
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + wv[i];
          if (pending_pad) begin
            pending_pad <= 1'b0;
            pad_second  <= 1'b0;
          end else if (final_block && pad_second) begin
            pad_second  <= 1'b0;
            final_block <= 1'b0;
          end
          emit_idx <= '0;
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
              fill_count  <= '0;
              byte_count  <= '0;
              final_block <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output beat.
  always_comb begin
    out_ch.valid       = (state == ST_EMIT);
    out_ch.digest_word = hash_words[emit_idx];
    out_ch.word_index  = emit_idx;
    out_ch.last_word   = (emit_idx == 3'd7);
  end

  // Input is only taken while collecting bytes.
  a_ready_collect: assert property (@(posedge clk) disable iff (rst)
    in_ready_w |-> state == ST_COLLECT) else $error("ready outside collect");
  // A round pass always ends in the hash update.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && step == 7'd63) |=> state == ST_UPDATE)
    else $error("round pass did not end in update");
  // Emission covers words in increasing order.
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && emit_idx != 3'd7) |=> emit_idx == $past(emit_idx) + 3'd1)
    else $error("digest word order broken");
endmodule
`default_nettype wire

FILE: sim/tb_sha256_byte_stream_hasher.sv
// Self-checking testbench for the SHA-256 byte-stream hasher.
// Depends on sha256_pkg, sha256_byte_if, sha256_digest_if and the hasher RTL.
module tb_sha256_byte_stream_hasher;
  import sha256_pkg::*;

  logic clk;
  logic rst;
  sha256_byte_if   in_ch (clk);
  sha256_digest_if out_ch (clk);

  sha256_byte_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Local copy of the hashing state.
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  fill_level;
  logic [60:0] byte_total;
  digest_beat_t digest_queue [$];

  int  error_count;
  int  cycle_count;
  bit  hold_off;
  bit  random_gaps;
  localparam int CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the local block into the chaining words.
  function automatic void compress_local();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] w, t1, t2, x2, x15, s0, s1;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        x2  = sched[(t - 2) & 15];
        x15 = sched[(t - 15) & 15];
        s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
        s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
        w = s1 + sched[(t - 7) & 15] + s0 + sched[t & 15];
        sched[t & 15] = w;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += v[i];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain_words[i] = INIT_HASH[i];
    fill_level = '0;
    byte_total = '0;
  endfunction

  // Advance the local hash by one accepted beat and queue any digest words.
  function automatic void hash_beat(logic [7:0] b, logic hb, logic eom);
    logic [63:0] bit_len;
    if (hb) begin
      block_bytes[fill_level] = b;
      fill_level = fill_level + 6'd1;
      byte_total = byte_total + 61'd1;
      if (fill_level == 0) compress_local();
    end
    if (!eom) return;
    block_bytes[fill_level] = PAD_BYTE;
    fill_level = fill_level + 6'd1;
    if (fill_level > 56 || fill_level == 0) begin
      if (fill_level != 0)
        for (int i = fill_level; i < 64; i++) block_bytes[i] = 8'h00;
      compress_local();
      fill_level = '0;
    end
    for (int i = fill_level; i < 56; i++) block_bytes[i] = 8'h00;
    bit_len = {byte_total, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[(7 - i) * 8 +: 8];
    compress_local();
    for (int i = 0; i < 8; i++) begin
      digest_queue.push_back('{word: chain_words[i], index: 3'(i), last: (i == 7)});
    end
    restart_message();
  endfunction

  // Offer one beat after a random gap and wait until it is accepted.
  task automatic send_beat(logic [7:0] b, logic hb, logic eom);
    int gap;
    gap = random_gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte <= hb;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    hash_beat(b, hb, eom);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++) begin
      send_beat(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
    end
    if (!end_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b1);          // empty message
    send_beat(8'hff, 1'b0, 1'b0);          // idle beat, ignored
    send_beat(8'h61, 1'b1, 1'b0);          // "abc"
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);          // end marker with no byte
  endtask

  // End on a byte in slot 62, and with a separate end beat; both put the marker in the last block slot.
  task automatic test_block_boundaries();
    send_message(63, 1'b1);
    send_message(63, 1'b0);
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 12) begin
      int len;
      len = $urandom_range(0, 8);
      send_message(len, $urandom_range(0, 1));
      sent += len + 1;
    end
  endtask

  // Hold the digest side off while byte beats keep arriving.
  task automatic test_backpressure();
    hold_off = 1'b1;
    random_gaps = 1'b0;
    send_message(2, 1'b1);
    send_message(3, 1'b0);
    random_gaps = 1'b1;
  endtask

  // Digest sink with random stalls and a long hold-off.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = random_gaps ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        if (out_ch.valid) check_word();
      end
    end
  end

  task automatic check_word();
    digest_beat_t exp_beat;
    if (digest_queue.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("unexpected digest word %h", out_ch.digest_word);
      return;
    end
    exp_beat = digest_queue.pop_front();
    if (out_ch.digest_word !== exp_beat.word || out_ch.word_index !== exp_beat.index ||
        out_ch.last_word !== exp_beat.last) begin
      error_count++;
      if (error_count <= 10)
        $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b", exp_beat.word,
                 exp_beat.index, exp_beat.last, out_ch.digest_word, out_ch.word_index,
                 out_ch.last_word);
    end
  endtask

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int waited;
    error_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    random_gaps = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    restart_message();
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_block_boundaries();
    test_backpressure();
    test_random_messages();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (digest_queue.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
